>>> sv/sts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sts_pkg: shared definitions for the sine Taylor series block
// Widths, fixed-point constants, register indexes, sequencer states and the
// per-term divisor and reciprocal tables.
// ---------------------------------------------------------------------------
package sts_pkg;

	// Series and number format.
	localparam int MAX_TERMS = 8;
	localparam int FRAC_BITS = 28;

	// Field widths.
	localparam int X_W      = 32;
	localparam int EPS_W    = 29;
	localparam int TL_W     = 4;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 2;

	// Shared multiplier operands and product.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 35;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Datapath widths. x squared is at most 2^34, a raw term product
	// at most 2^37, and the divisor of a term is at most 272.
	localparam int X2_W    = 35;
	localparam int M_W     = 38;
	localparam int LO_W    = 16;
	localparam int N1_W    = M_W - LO_W;
	localparam int D_W     = 9;
	localparam int N2_W    = D_W + LO_W;
	localparam int Q1_W    = 20;
	localparam int Q2_W    = LO_W;
	localparam int Q_W     = Q1_W + Q2_W;
	localparam int RECIP_W = 32;
	localparam int RECIP_SHIFT = 34;
	localparam int IDX_W   = $clog2(MAX_TERMS);
	localparam int PREV_W  = X_W + 1;
	localparam int DIFF_W  = X_W + 2;

	localparam logic [X_W-1:0] TERM_POS_MAX = {1'b0, {(X_W-1){1'b1}}};
	localparam logic [X_W-1:0] TERM_NEG_MAX = {1'b1, {(X_W-1){1'b0}}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd2;

	localparam logic [TL_W-1:0]  TERM_LIMIT_RST = 4'd5;
	localparam logic [EPS_W-1:0] EPSILON_RST    = 29'd2684;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X2,
		ST_TERM,
		ST_MUL,
		ST_DIV1,
		ST_REM1,
		ST_DIV2,
		ST_REM2,
		ST_ROUND,
		ST_FIN
	} sts_state_t;

	// Divisor (2n)(2n+1) that turns term n into term n+1.
	function automatic logic [D_W-1:0] term_div(input logic [IDX_W-1:0] idx);
		logic [D_W-1:0] d;
		case (idx)
			3'd0:    d = 9'd6;
			3'd1:    d = 9'd20;
			3'd2:    d = 9'd42;
			3'd3:    d = 9'd72;
			3'd4:    d = 9'd110;
			3'd5:    d = 9'd156;
			3'd6:    d = 9'd210;
			3'd7:    d = 9'd272;
			default: d = 9'd6;
		endcase
		return d;
	endfunction

	// ceil(2^34 / divisor). Exact floor division of any dividend below 2^25.
	function automatic logic [RECIP_W-1:0] term_recip(input logic [IDX_W-1:0] idx);
		logic [RECIP_W-1:0] r;
		case (idx)
			3'd0:    r = 32'd2863311531;
			3'd1:    r = 32'd858993460;
			3'd2:    r = 32'd409044505;
			3'd3:    r = 32'd238609295;
			3'd4:    r = 32'd156180629;
			3'd5:    r = 32'd110127367;
			3'd6:    r = 32'd81808901;
			3'd7:    r = 32'd63161284;
			default: r = 32'd2863311531;
		endcase
		return r;
	endfunction

endpackage

>>> sv/sts_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sts_mul: shared unsigned multiplier
// The only multiplier of the block; the sequencer registers its product.
// ---------------------------------------------------------------------------
module sts_mul
	import sts_pkg::*;
(
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [PROD_W-1:0]  p
);

	assign p = {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};

endmodule

>>> sv/sine_taylor_series.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sine_taylor_series: fixed-point sine by partial Taylor sums
// Sums x - x^3/3! + x^5/5! - ... in signed Q3.28 on one shared multiplier.
// ---------------------------------------------------------------------------
// Usage. The argument x_value arrives on the slave stream (s_tdata). One
// result per argument leaves on the master stream: sine_sum and terms_used in
// m_tdata, the cap_reached and overflowed flags in m_tuser. The user writes
// the three registers (stop_mode, term_limit, epsilon) via cfg_we, cfg_index
// and cfg_data only while the block is idle; the block does not enforce it.
// Sequencing: the evaluation of an argument adds at most eight terms.
// Every term takes seven sequencer steps: the product with x squared,
// then two reciprocal multiplies and two remainder multiplies for the exact
// rounded division by (2n)(2n+1), one rounding step and one accumulate step.
// The multiplying steps share one multiplier, so one argument is in flight
// at a time and s_tready is high only while the sequencer is idle: the next
// transfer is taken only after the previous result has left the sequencer.
// The result sits in an output register; the next argument is taken while it
// waits. If the receiver stalls, the finished sum waits in the sequencer until
// the output register frees up.
// Reset clears the sequencer and the output valid and restores the register
// defaults (count mode, five terms, epsilon 2684).
// ---------------------------------------------------------------------------
module sine_taylor_series
	import sts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EPS_W-1:0]     cfg_data,
	// Argument stream. s_tdata: [31:0] x_value.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,
	// Result stream. m_tdata: [31:0] sine_sum, [35:32] terms_used, [39:36] zero.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,
	// m_tuser: [0] cap_reached, [1] overflowed.
	output logic [1:0]           m_tuser
);

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	sts_state_t state_q, state_d;

	// Configuration registers.
	logic              stop_mode_q;
	logic [TL_W-1:0]   term_limit_q;
	logic [EPS_W-1:0]  epsilon_q;

	// Working registers of one evaluation.
	logic [X_W-1:0]           xmag_q;
	logic [X2_W-1:0]          x2_q;
	logic [X_W-1:0]           tmag_q;
	logic                     tneg_q;
	logic [M_W-1:0]           m_q;
	logic [Q1_W-1:0]          q1_q;
	logic [Q2_W-1:0]          q2_q;
	logic [D_W-1:0]           r1_q;
	logic [D_W-1:0]           r2_q;
	logic signed [X_W-1:0]    sum_q;
	logic signed [PREV_W-1:0] prev_q;
	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         limit_q;
	logic                     ovf_q;
	logic                     cap_q;

	// Output register.
	logic                     out_valid_q;
	logic [X_W-1:0]           out_sum_q;
	logic [CNT_W-1:0]         out_used_q;
	logic                     out_cap_q;
	logic                     out_ovf_q;

	// Shared multiplier.
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  prod_rnd;

	sts_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (prod)
	);

	assign prod_rnd = prod + ROUND_HALF;

	// Term index: the term being formed follows term number used_q.
	logic [CNT_W-1:0] used_m1;
	logic [IDX_W-1:0] tidx;
	logic [D_W-1:0]   dval;
	logic [RECIP_W-1:0] rval;

	assign used_m1 = used_q - CNT_W'(1);
	assign tidx    = used_m1[IDX_W-1:0];
	assign dval    = term_div(tidx);
	assign rval    = term_recip(tidx);

	// The rounded division runs as two steps of long division in base 2^16:
	// the high part of the product first, then its remainder with the low half.
	logic [N2_W-1:0] num1;
	logic [N2_W-1:0] num2;
	logic [N2_W-1:0] rem_full;

	assign num1 = {{(N2_W-N1_W){1'b0}}, m_q[M_W-1:LO_W]};
	assign num2 = {r1_q, m_q[LO_W-1:0]};
	assign rem_full = (state_q == ST_REM1) ? num1 - prod[N2_W-1:0]
	                                       : num2 - prod[N2_W-1:0];

	// Rounding half up on the remainder, then clamping the magnitude to what
	// a term of the new sign may hold.
	logic           round_up;
	logic [Q_W-1:0] q_rnd;
	logic           tneg_next;
	logic [X_W-1:0] term_lim;
	logic           term_sat;

	assign round_up  = {r2_q, 1'b0} >= {1'b0, dval};
	assign q_rnd     = {q1_q, q2_q} + Q_W'(round_up);
	assign tneg_next = !tneg_q;
	assign term_lim  = tneg_next ? TERM_NEG_MAX : TERM_POS_MAX;
	assign term_sat  = q_rnd > {{(Q_W-X_W){1'b0}}, term_lim};

	// Accumulate step: the current term is added with its sign, and in
	// epsilon mode compared against the previous one.
	logic signed [DIFF_W-1:0] tmag_x;
	logic signed [DIFF_W-1:0] sum_x;
	logic signed [DIFF_W-1:0] prev_x;
	logic signed [DIFF_W-1:0] sum_next;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] eps_x;
	logic signed [PREV_W-1:0] tmag_p;
	logic signed [PREV_W-1:0] tv;
	logic                     sum_hi;
	logic                     sum_lo;
	logic                     term_full;
	logic                     term_close;
	logic                     term_stop;

	assign tmag_x   = $signed({2'b00, tmag_q});
	assign sum_x    = DIFF_W'(sum_q);
	assign prev_x   = DIFF_W'(prev_q);
	assign sum_next = tneg_q ? sum_x - tmag_x : sum_x + tmag_x;
	assign diff     = tneg_q ? prev_x + tmag_x : prev_x - tmag_x;
	assign eps_x    = $signed({{(DIFF_W-EPS_W){1'b0}}, epsilon_q});
	assign tmag_p   = $signed({1'b0, tmag_q});
	assign tv       = tneg_q ? -tmag_p : tmag_p;

	// The sum leaves the 32-bit range when the three top bits disagree.
	assign sum_hi = !sum_next[DIFF_W-1] && (sum_next[DIFF_W-2] || sum_next[DIFF_W-3]);
	assign sum_lo = sum_next[DIFF_W-1] && !(sum_next[DIFF_W-2] && sum_next[DIFF_W-3]);

	assign term_full  = used_q >= limit_q;
	assign term_close = (diff < eps_x) && (diff > -eps_x);
	assign term_stop  = term_full || (stop_mode_q && term_close);

	logic out_free;
	logic out_load;
	logic in_xfer;

	assign out_free = !out_valid_q || m_tready;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_X2;
			ST_X2:    state_d = ST_TERM;
			ST_TERM:  state_d = term_stop ? ST_FIN : ST_MUL;
			ST_MUL:   state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_REM1;
			ST_REM1:  state_d = ST_DIV2;
			ST_DIV2:  state_d = ST_REM2;
			ST_REM2:  state_d = ST_ROUND;
			ST_ROUND: state_d = ST_TERM;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operand selection.
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_X2: begin
				mul_a = xmag_q;
				mul_b = {{(MUL_B_W-X_W){1'b0}}, xmag_q};
			end
			ST_MUL: begin
				mul_a = tmag_q;
				mul_b = x2_q;
			end
			ST_DIV1: begin
				mul_a = {{(MUL_A_W-N2_W){1'b0}}, num1};
				mul_b = {{(MUL_B_W-RECIP_W){1'b0}}, rval};
			end
			ST_REM1: begin
				mul_a = {{(MUL_A_W-Q1_W){1'b0}}, q1_q};
				mul_b = {{(MUL_B_W-D_W){1'b0}}, dval};
			end
			ST_DIV2: begin
				mul_a = {{(MUL_A_W-N2_W){1'b0}}, num2};
				mul_b = {{(MUL_B_W-RECIP_W){1'b0}}, rval};
			end
			ST_REM2: begin
				mul_a = {{(MUL_A_W-Q2_W){1'b0}}, q2_q};
				mul_b = {{(MUL_B_W-D_W){1'b0}}, dval};
			end
			ST_FIN: out_load = out_free;
			default: begin
			end
		endcase
	end

	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mode_q  <= 1'b0;
			term_limit_q <= TERM_LIMIT_RST;
			epsilon_q    <= EPSILON_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STOP_MODE:  stop_mode_q  <= cfg_data[0];
				REG_TERM_LIMIT: term_limit_q <= cfg_data[TL_W-1:0];
				REG_EPSILON:    epsilon_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			// The magnitude of the most negative argument is 2^31, which the
			// unsigned 32-bit negation gives directly.
			xmag_q  <= s_tdata[X_W-1] ? (~s_tdata + 32'd1) : s_tdata;
			tmag_q  <= s_tdata[X_W-1] ? (~s_tdata + 32'd1) : s_tdata;
			tneg_q  <= s_tdata[X_W-1];
			sum_q   <= '0;
			prev_q  <= '0;
			used_q  <= '0;
			ovf_q   <= 1'b0;
			cap_q   <= 1'b0;
			if (stop_mode_q || (term_limit_q > TL_W'(MAX_TERMS))) begin
				limit_q <= CNT_W'(MAX_TERMS);
			end else begin
				limit_q <= CNT_W'(term_limit_q);
			end
		end
		case (state_q)
			ST_X2:   x2_q <= prod_rnd[FRAC_BITS +: X2_W];
			ST_MUL:  m_q  <= prod_rnd[FRAC_BITS +: M_W];
			ST_DIV1: q1_q <= prod[RECIP_SHIFT +: Q1_W];
			ST_REM1: r1_q <= rem_full[D_W-1:0];
			ST_DIV2: q2_q <= prod[RECIP_SHIFT +: Q2_W];
			ST_REM2: r2_q <= rem_full[D_W-1:0];
			ST_ROUND: begin
				tneg_q <= tneg_next;
				if (term_sat) begin
					tmag_q <= term_lim;
					ovf_q  <= 1'b1;
				end else begin
					tmag_q <= q_rnd[X_W-1:0];
				end
			end
			ST_TERM: begin
				if (term_full) begin
					cap_q <= stop_mode_q;
				end else if (!term_stop) begin
					if (sum_hi) begin
						sum_q <= $signed(TERM_POS_MAX);
						ovf_q <= 1'b1;
					end else if (sum_lo) begin
						sum_q <= $signed(TERM_NEG_MAX);
						ovf_q <= 1'b1;
					end else begin
						sum_q <= sum_next[X_W-1:0];
					end
					prev_q <= tv;
					used_q <= used_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sum_q  <= sum_q;
			out_used_q <= used_q;
			out_cap_q  <= cap_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_used_q, out_sum_q};
	assign m_tuser  = {out_ovf_q, out_cap_q};

endmodule

>>> sv/sts_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sts_checker: port-level assertions for the sine Taylor series block
// Watches the streams of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module sts_checker
	import sts_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [39:0]          m_tdata,
	input logic [1:0]           m_tuser
);

	// One argument at a time: the block is busy right after taking one.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("s_tready high in the cycle after an argument transfer");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

	a_terms_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[35:32] <= CNT_W'(MAX_TERMS))
		else $error("terms_used above the term cap");

	// The cap flag only comes with a full count of terms.
	a_cap_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[35:32] == CNT_W'(MAX_TERMS))
		else $error("cap_reached without the full term count");

endmodule

bind sine_taylor_series sts_checker u_sts_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the fixed-point sine Taylor series block
// Drives arguments on the slave stream and writes the three registers between
// phases. Every result transfer is checked against a bit-exact predictor
// kept in the bench or a typed-in expectation. The sequence is a directed
// table of corner cases, then random arguments under random register
// settings, with three patterns of sender and receiver idling.
// ---------------------------------------------------------------------------
module tb_top;
	import sts_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 4;
	// Settle time long enough to cover a full evaluation of eight terms.
	localparam int SETTLE_CYCLES   = 64;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int PHASES_PER_IDLE = 5;
	localparam int ITEMS_PER_PHASE = 102;
	localparam int REPORT_LIMIT    = 10;

	// pi in Q3.28, the edge of the range where the series is actually useful.
	localparam logic [31:0] PI_Q28 = 32'd843314857;
	localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

	localparam logic signed [63:0] SUM_HI = 64'sd2147483647;
	localparam logic signed [63:0] SUM_LO = -64'sd2147483648;

	// One result as it appears on the master stream.
	typedef struct packed {
		logic [31:0] sum;
		logic [3:0]  terms;
		logic        cap;
		logic        ovf;
	} sine_res_t;

	// One row of the directed table: register setting, argument, and an
	// optional hand-written expectation.
	typedef struct packed {
		logic             mode;
		logic [TL_W-1:0]  limit;
		logic [EPS_W-1:0] eps;
		logic [31:0]      x;
		logic             typed;
		sine_res_t        res;
	} sine_vec_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [EPS_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;
	logic [1:0]           m_tuser;

	// Shadow copy of the block's registers, updated on every write.
	logic             sh_mode;
	logic [TL_W-1:0]  sh_limit;
	logic [EPS_W-1:0] sh_eps;

	sine_res_t pending_sines[$];
	sine_vec_t dir_vecs[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	int results_seen;
	int args_sent;
	int settings_used;
	int cycle_count;

	sine_taylor_series u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Hard stop in case the block hangs or drops a result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_sines.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver side: ready is rerolled at every falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Partial sum of the sine series for argument x under the shadow registers.
	// All rounding is done on magnitudes, half away from zero, and terms and
	// the running sum are clamped to the signed 32-bit range.
	function automatic sine_res_t taylor_sine(input logic [31:0] x);
		logic               xneg;
		logic               tneg;
		logic               by_eps;
		logic               done;
		logic               ovf;
		logic               big;
		logic [31:0]        negx;
		logic [63:0]        xmag;
		logic [63:0]        x2;
		logic [63:0]        tmag;
		logic [63:0]        m;
		logic [63:0]        d;
		logic [63:0]        clamp;
		logic [63:0]        gap;
		logic [63:0]        limit;
		logic [63:0]        used;
		logic [63:0]        n;
		logic [127:0]       prod;
		logic signed [63:0] tv;
		logic signed [63:0] prev;
		logic signed [63:0] sum;
		logic signed [63:0] diff;
		sine_res_t          r;

		xneg = x[31];
		// Two's complement negate in 32 bits: the most negative input maps
		// onto a magnitude of exactly 2^31.
		negx = ~x + 32'd1;
		xmag = xneg ? {32'd0, negx} : {32'd0, x};
		x2 = (xmag * xmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

		by_eps = sh_mode;
		limit = by_eps ? 64'(MAX_TERMS) : {60'd0, sh_limit};
		if (limit > 64'(MAX_TERMS))
			limit = 64'(MAX_TERMS);

		ovf = 1'b0;
		done = 1'b0;
		tneg = xneg;
		tmag = xmag;
		prev = 64'sd0;
		sum = 64'sd0;
		used = 64'd0;
		n = 64'd1;

		while (!done && used < limit) begin
			tv = tneg ? -$signed(tmag) : $signed(tmag);
			if (by_eps) begin
				diff = prev - tv;
				gap = (diff < 0) ? 64'(-diff) : 64'(diff);
				if (gap < {35'd0, sh_eps})
					done = 1'b1;
			end
			if (!done) begin
				sum = sum + tv;
				if (sum > SUM_HI) begin
					sum = SUM_HI;
					ovf = 1'b1;
				end
				if (sum < SUM_LO) begin
					sum = SUM_LO;
					ovf = 1'b1;
				end
				prev = tv;
				used = used + 64'd1;

				// Next term: multiply by x^2, then divide by (2n)(2n+1), each
				// step rounded to nearest.
				prod = {64'd0, tmag} * {64'd0, x2} + (128'd1 << (FRAC_BITS - 1));
				big = (prod >> (64 + FRAC_BITS)) != 128'd0;
				m = prod[64+FRAC_BITS-1:FRAC_BITS];
				d = (64'd2 * n) * (64'd2 * n + 64'd1);
				m = m / d + ((((m % d) * 64'd2) >= d) ? 64'd1 : 64'd0);
				tneg = !tneg;
				clamp = tneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
				if (big || m > clamp) begin
					m = clamp;
					ovf = 1'b1;
				end
				tmag = m;
				n = n + 64'd1;
			end
		end

		r.sum = sum[31:0];
		r.terms = (used > 64'd15) ? 4'd15 : used[3:0];
		// The cap flag only rises when epsilon mode ran out of terms.
		r.cap = by_eps && !done;
		r.ovf = ovf;
		return r;
	endfunction

	// Counts a failure and prints the first few of them.
	task automatic flag_error(input string what, input sine_res_t want, input sine_res_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t %s: expected sum %h terms %0d cap %b ovf %b, got sum %h terms %0d cap %b ovf %b",
				$realtime, what, want.sum, want.terms, want.cap, want.ovf,
				got.sum, got.terms, got.cap, got.ovf);
	endtask

	// Every result transfer is compared with the oldest outstanding prediction.
	always @(posedge clk) begin : check_results
		sine_res_t got;
		sine_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.sum = m_tdata[31:0];
			got.terms = m_tdata[35:32];
			got.cap = m_tuser[0];
			got.ovf = m_tuser[1];
			results_seen++;
			if (pending_sines.size() == 0) begin
				want = '0;
				flag_error("result with nothing outstanding", want, got);
			end else begin
				want = pending_sines.pop_front();
				if (got !== want)
					flag_error("result mismatch", want, got);
			end
		end
	end

	// Offers one argument on the slave stream and records what it should give.
	// The valid stays up after the transfer until the next falling edge, where
	// the next call either replaces the data or idles.
	task automatic send_argument(input logic [31:0] x, input logic typed, input sine_res_t res);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = x;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_sines.push_back(typed ? res : taylor_sine(x));
		args_sent++;
	endtask

	// Registers are only touched with nothing in flight: all results are back,
	// then one full evaluation time passes.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_sines.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EPS_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_STOP_MODE:  sh_mode = val[0];
			REG_TERM_LIMIT: sh_limit = val[TL_W-1:0];
			REG_EPSILON:    sh_eps = val;
			default: ;
		endcase
	endtask

	// Moves to a new register setting, writing only what changes.
	task automatic apply_setting(input logic mode, input logic [TL_W-1:0] limit,
		input logic [EPS_W-1:0] eps);
		if (mode == sh_mode && limit == sh_limit && eps == sh_eps)
			return;
		wait_idle();
		if (mode != sh_mode)
			write_reg(REG_STOP_MODE, {{(EPS_W-1){1'b0}}, mode});
		if (limit != sh_limit)
			write_reg(REG_TERM_LIMIT, {{(EPS_W-TL_W){1'b0}}, limit});
		if (eps != sh_eps)
			write_reg(REG_EPSILON, eps);
		settings_used++;
	endtask

	task automatic add_row(input logic mode, input logic [TL_W-1:0] limit,
		input logic [EPS_W-1:0] eps, input logic [31:0] x, input logic typed,
		input logic [31:0] sum, input logic [3:0] terms, input logic cap, input logic ovf);
		sine_vec_t v;
		v.mode = mode;
		v.limit = limit;
		v.eps = eps;
		v.x = x;
		v.typed = typed;
		v.res = '{sum: sum, terms: terms, cap: cap, ovf: ovf};
		dir_vecs.push_back(v);
	endtask

	// Random argument: mostly within plus or minus pi, with tiny values, the
	// full 32-bit range and values next to both ends mixed in.
	function automatic logic [31:0] rand_argument();
		logic [31:0] mag;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			mag = $urandom_range(0, PI_Q28);
		else if (pick < 55)
			mag = $urandom_range(0, 65535);
		else if (pick < 85)
			return $urandom;
		else
			mag = 32'h8000_0000 - $urandom_range(0, 4095);
		return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
	endfunction

	function automatic logic [EPS_W-1:0] rand_epsilon();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return 29'd1;
			2:       return EPSILON_RST;
			3:       return 29'h1000_0000;
			4:       return {EPS_W{1'b1}};
			5:       return EPS_W'($urandom_range(0, 268435456));
			default: return EPS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic             mode;
		logic [TL_W-1:0]  limit;
		logic [EPS_W-1:0] eps;
		int               n_dir;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		sh_mode = 1'b0;
		sh_limit = TERM_LIMIT_RST;
		sh_eps = EPSILON_RST;
		send_idle_pct = 31;
		recv_idle_pct = 73;
		mismatch_count = 0;
		results_seen = 0;
		args_sent = 0;
		settings_used = 1;
		cycle_count = 0;

		// Directed table. Expectations are typed in only where they follow
		// directly from the definition; the other rows use the predictor.
		// Reset setting: count mode, five terms. A zero argument sums five zeros.
		add_row(0, 5, EPSILON_RST, 32'h0000_0000, 1, 32'h0, 5, 0, 0);
		add_row(0, 5, EPSILON_RST, ONE_Q28,       0, 32'h0, 0, 0, 0);
		add_row(0, 5, EPSILON_RST, 32'h7FFF_FFFF, 0, 32'h0, 0, 0, 0);
		add_row(0, 5, EPSILON_RST, 32'h8000_0000, 0, 32'h0, 0, 0, 0);
		add_row(0, 5, EPSILON_RST, 32'hFFFF_FFFF, 0, 32'h0, 0, 0, 0);
		// A zero term limit adds nothing.
		add_row(0, 0, EPSILON_RST, 32'h1234_5678, 1, 32'h0, 0, 0, 0);
		// One term is x itself; the next term of 1.0 is 1/6, no saturation.
		add_row(0, 1, EPSILON_RST, ONE_Q28,       1, ONE_Q28, 1, 0, 0);
		add_row(0, 1, EPSILON_RST, 32'h8000_0000, 0, 32'h0, 0, 0, 0);
		// Full-range arguments saturate terms, and the negative one the sum.
		add_row(0, 8, EPSILON_RST, 32'h7FFF_FFFF, 0, 32'h0, 0, 0, 0);
		add_row(0, 8, EPSILON_RST, 32'h8000_0000, 0, 32'h0, 0, 0, 0);
		add_row(0, 8, EPSILON_RST, 32'hC000_0000, 0, 32'h0, 0, 0, 0);
		// A term limit above the maximum acts as the maximum.
		add_row(0, 15, EPSILON_RST, 32'h2000_0000, 0, 32'h0, 0, 0, 0);
		// Zero epsilon never converges: all eight terms, cap flag set.
		add_row(1, 15, 29'd0,       32'h0000_0000, 1, 32'h0, 8, 1, 0);
		add_row(1, 8, 29'd0,        ONE_Q28,       0, 32'h0, 0, 0, 0);
		// A zero argument converges at once in epsilon mode.
		add_row(1, 8, EPSILON_RST,  32'h0000_0000, 1, 32'h0, 0, 0, 0);
		add_row(1, 8, EPSILON_RST,  32'h3243_F6A8, 0, 32'h0, 0, 0, 0);
		add_row(1, 8, EPSILON_RST,  ONE_Q28,       0, 32'h0, 0, 0, 0);
		add_row(1, 8, EPSILON_RST,  32'hFFFF_FFFF, 0, 32'h0, 0, 0, 0);
		// The widest epsilon stops before the first term of 1.0.
		add_row(1, 8, {EPS_W{1'b1}}, ONE_Q28,      1, 32'h0, 0, 0, 0);
		add_row(1, 8, 29'h1000_0000, ONE_Q28,      0, 32'h0, 0, 0, 0);
		add_row(1, 8, 29'd1,        32'h7FFF_FFFF, 0, 32'h0, 0, 0, 0);
		add_row(1, 8, 29'd1,        32'h8000_0000, 0, 32'h0, 0, 0, 0);
		// Epsilon mode ignores the term limit.
		add_row(1, 3, EPSILON_RST,  32'h0800_0000, 0, 32'h0, 0, 0, 0);
		// Count mode never sets the cap flag, whatever epsilon holds.
		add_row(0, 3, 29'h1000_0000, 32'hF000_0000, 0, 32'h0, 0, 0, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		n_dir = dir_vecs.size();
		foreach (dir_vecs[i]) begin
			apply_setting(dir_vecs[i].mode, dir_vecs[i].limit, dir_vecs[i].eps);
			send_argument(dir_vecs[i].x, dir_vecs[i].typed, dir_vecs[i].res);
		end

		// Random part: three idling patterns, each with several register
		// settings. Term limits lean toward the legal one to eight.
		for (int ip = 0; ip < 3; ip++) begin
			case (ip)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 73;
				end
				1: begin
					send_idle_pct = 73;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int ph = 0; ph < PHASES_PER_IDLE; ph++) begin
				mode = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 70)
					limit = TL_W'($urandom_range(1, 8));
				else
					limit = TL_W'($urandom_range(0, 15));
				eps = rand_epsilon();
				apply_setting(mode, limit, eps);
				for (int k = 0; k < ITEMS_PER_PHASE; k++)
					send_argument(rand_argument(), 1'b0, '0);
			end
		end

		wait_idle();

		$display("sent %0d arguments (%0d from the corner table) under %0d register settings",
			args_sent, n_dir, settings_used);
		$display("checked %0d results across three idling patterns, %0d mismatches",
			results_seen, mismatch_count);
		if (mismatch_count == 0 && pending_sines.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/sts_pkg.sv
sv/sts_mul.sv
sv/sine_taylor_series.sv
sv/sts_checker.sv
sim/tb_top.sv
